>>> rtl/clir_pkg.sv
// Package for the circular list store with indexed removal.
// Sizes, request and status codes, sequencer states, memory write port type.
// Used by every module in rtl; depends on nothing.
package clir_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int POS_W      = 8;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int BIT_W      = $clog2(POS_W);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [BIT_W-1:0]      bitidx_t;
  typedef logic [POS_W-1:0]      pos_t;

  typedef enum logic [1:0] {
    ACT_PUSH        = 2'd0,
    ACT_REMOVE_AT   = 2'd1,
    ACT_REMOVE_LAST = 2'd2,
    ACT_NOP         = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_MOD,
    S_READ,
    S_CAPT,
    S_SH_RD,
    S_SH_WR
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t addr;
    word_t data;
  } mem_wr_t;

endpackage

>>> rtl/clir_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on clir_pkg.
module clir_mem (
  input  logic             clk,
  input  clir_pkg::mem_wr_t wr,
  input  clir_pkg::addr_t  raddr,
  output clir_pkg::word_t  rdata
);

  clir_pkg::word_t mem [clir_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/clir_step.sv
// Compare/subtract unit: one restoring remainder step per cycle.
// Depends on clir_pkg.
module clir_step (
  input  clir_pkg::cnt_t rem,
  input  logic           bit_in,
  input  clir_pkg::cnt_t divisor,
  output clir_pkg::cnt_t rem_out
);

  logic [clir_pkg::CNT_W:0] shifted;
  logic [clir_pkg::CNT_W:0] trial;
  logic                     ge;

  assign shifted = {rem, bit_in};
  assign trial   = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};
  assign rem_out = ge ? trial[clir_pkg::CNT_W-1:0] : shifted[clir_pkg::CNT_W-1:0];

endmodule

>>> rtl/circular_list_indexed_removal.sv
// Circular list store with push, remove at position and remove last.
// Push, no-op, empty/full rejects: result decided in the dispatch state and registered.
// Remove last: read, capture, result. Remove at position: 8 remainder steps on the
// subtractor, then read, capture and each later entry shifted down (read, then write).
// One request at a time; busy stays high until the result strobe; results are never stalled.
// Synchronous reset empties the store; entry contents stay undefined until written.
module circular_list_indexed_removal (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] value,
  input  logic [7:0]  position,
  output logic        done,
  output logic [31:0] removed_value,
  output logic [1:0]  status,
  output logic [4:0]  entry_count
);

  clir_pkg::state_t  state, state_next;
  clir_pkg::action_t act, act_next;
  clir_pkg::word_t   val, val_next;
  clir_pkg::pos_t    pos, pos_next;
  clir_pkg::cnt_t    count, count_next;
  clir_pkg::cnt_t    rem, rem_next;
  clir_pkg::bitidx_t bitidx, bitidx_next;
  clir_pkg::addr_t   ptr, ptr_next;
  clir_pkg::word_t   word, word_next;
  logic              done_next;
  logic [31:0]       removed_value_next;
  logic [1:0]        status_next;
  logic [4:0]        entry_count_next;

  clir_pkg::mem_wr_t mem_wr;
  clir_pkg::addr_t   raddr;
  clir_pkg::word_t   rdata;
  clir_pkg::cnt_t    step_rem;
  clir_pkg::cnt_t    ptr_inc;

  clir_mem u_mem (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  clir_step u_step (
    .rem     (rem),
    .bit_in  (pos[bitidx]),
    .divisor (count),
    .rem_out (step_rem)
  );

  assign busy    = (state != clir_pkg::S_IDLE);
  assign ptr_inc = clir_pkg::cnt_t'(ptr) + clir_pkg::cnt_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clir_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    act           <= act_next;
    val           <= val_next;
    pos           <= pos_next;
    rem           <= rem_next;
    bitidx        <= bitidx_next;
    ptr           <= ptr_next;
    word          <= word_next;
    removed_value <= removed_value_next;
    status        <= status_next;
    entry_count   <= entry_count_next;
  end

  always_comb begin
    state_next         = state;
    act_next           = act;
    val_next           = val;
    pos_next           = pos;
    count_next         = count;
    rem_next           = rem;
    bitidx_next        = bitidx;
    ptr_next           = ptr;
    word_next          = word;
    done_next          = 1'b0;
    removed_value_next = removed_value;
    status_next        = status;
    entry_count_next   = entry_count;
    mem_wr.we          = 1'b0;
    mem_wr.addr        = ptr;
    mem_wr.data        = rdata;
    raddr              = ptr;

    case (state)
      clir_pkg::S_IDLE: begin
        if (start) begin
          act_next   = clir_pkg::action_t'(action);
          val_next   = clir_pkg::word_t'(value);
          pos_next   = position;
          state_next = clir_pkg::S_DISPATCH;
        end
      end
      clir_pkg::S_DISPATCH: begin
        removed_value_next = '0;
        status_next        = clir_pkg::ST_DONE;
        entry_count_next   = 5'(count);
        case (act)
          clir_pkg::ACT_PUSH: begin
            done_next  = 1'b1;
            state_next = clir_pkg::S_IDLE;
            if (count == clir_pkg::cnt_t'(clir_pkg::DEPTH)) begin
              status_next = clir_pkg::ST_FULL;
            end else begin
              mem_wr.we        = 1'b1;
              mem_wr.addr      = clir_pkg::addr_t'(count);
              mem_wr.data      = val;
              count_next       = count + clir_pkg::cnt_t'(1);
              entry_count_next = 5'(count + clir_pkg::cnt_t'(1));
            end
          end
          clir_pkg::ACT_REMOVE_AT, clir_pkg::ACT_REMOVE_LAST: begin
            if (count == '0) begin
              status_next = clir_pkg::ST_EMPTY;
              done_next   = 1'b1;
              state_next  = clir_pkg::S_IDLE;
            end else if (act == clir_pkg::ACT_REMOVE_LAST) begin
              ptr_next   = clir_pkg::addr_t'(count - clir_pkg::cnt_t'(1));
              state_next = clir_pkg::S_READ;
            end else begin
              rem_next    = '0;
              bitidx_next = clir_pkg::bitidx_t'(clir_pkg::POS_W - 1);
              state_next  = clir_pkg::S_MOD;
            end
          end
          default: begin
            done_next  = 1'b1;
            state_next = clir_pkg::S_IDLE;
          end
        endcase
      end
      clir_pkg::S_MOD: begin
        rem_next = step_rem;
        if (bitidx == '0) begin
          ptr_next   = clir_pkg::addr_t'(step_rem);
          state_next = clir_pkg::S_READ;
        end else begin
          bitidx_next = bitidx - clir_pkg::bitidx_t'(1);
        end
      end
      clir_pkg::S_READ: begin
        raddr      = ptr;
        state_next = clir_pkg::S_CAPT;
      end
      clir_pkg::S_CAPT: begin
        word_next  = rdata;
        state_next = clir_pkg::S_SH_RD;
      end
      clir_pkg::S_SH_RD: begin
        if (ptr_inc < count) begin
          raddr      = ptr + clir_pkg::addr_t'(1);
          state_next = clir_pkg::S_SH_WR;
        end else begin
          count_next         = count - clir_pkg::cnt_t'(1);
          removed_value_next = 32'(word);
          status_next        = clir_pkg::ST_DONE;
          entry_count_next   = 5'(count - clir_pkg::cnt_t'(1));
          done_next          = 1'b1;
          state_next         = clir_pkg::S_IDLE;
        end
      end
      clir_pkg::S_SH_WR: begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = ptr;
        mem_wr.data = rdata;
        ptr_next    = ptr + clir_pkg::addr_t'(1);
        state_next  = clir_pkg::S_SH_RD;
      end
      default: begin
        state_next = clir_pkg::S_IDLE;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted request did not raise busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status == clir_pkg::ST_FULL |-> entry_count == 5'(clir_pkg::DEPTH))
    else $error("full status with store not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && status == clir_pkg::ST_EMPTY |-> entry_count == 5'd0 && removed_value == 32'd0)
    else $error("empty status with nonzero count or value");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> entry_count <= 5'(clir_pkg::DEPTH))
    else $error("entry count out of range");

endmodule
